/* hw/rtl/assert_macros.svh */
// Assertion macros included by the splitter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/uspq_pkg.sv */
// Types and constants shared by the URL scheme/path/query splitter.
`timescale 1ns / 1ps

package uspq_pkg;

    // Input transaction: one byte of URL text
    typedef struct packed {
        logic [7:0] byte_in;
        logic       url_last;
    } in_t;

    // Output transaction: one tagged byte or a marker
    typedef struct packed {
        logic [1:0] part;
        logic [7:0] value;
        logic [1:0] error_code;
        logic       url_end;
        logic       run_end;
    } out_t;

    localparam logic [1:0] PART_SCHEME = 2'd0;
    localparam logic [1:0] PART_PATH   = 2'd1;
    localparam logic [1:0] PART_QUERY  = 2'd2;
    localparam logic [1:0] PART_NONE   = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_CTRL_CHAR = 2'd1;
    localparam logic [1:0] ERR_NO_SCHEME = 2'd2;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    typedef enum logic [1:0] {
        PH_SCHEME = 2'd0,
        PH_PATH   = 2'd1,
        PH_QUERY  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_TAIL = 4'b1000
    } ctrl_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic take;        // input transaction accepted
        logic rd;          // read held candidate at flush index
        logic emit_flush;  // load read candidate into output register
        logic emit_tail;   // load trailing path byte into output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_flush;  // accepted byte releases held candidates
        logic flush_last;  // flush index is at the last held candidate
        logic has_tail;    // a path byte follows the flushed candidates
        logic out_free;    // output register can load this cycle
    } sts_t;

endpackage

/* hw/rtl/uspq_dp.sv */
// Datapath: byte classification, candidate buffer, phase state and output register.
`timescale 1ns / 1ps

module uspq_dp #(
    parameter int SCHEME_MAX = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  uspq_pkg::in_t  in_data,
    input  uspq_pkg::cmd_t cmd,
    output uspq_pkg::sts_t sts,
    output logic           out_valid,
    input  logic           out_stall,
    output uspq_pkg::out_t out_data
);

    localparam int CNT_W = $clog2(SCHEME_MAX + 1);
    localparam int IDX_W = $clog2(SCHEME_MAX);

    uspq_pkg::phase_t   phase_reg, phase_next;
    logic               discard_reg, discard_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;

    logic [7:0]         buf_mem [SCHEME_MAX];
    logic [7:0]         rd_reg;
    logic [7:0]         hold_byte_reg;
    logic               hold_last_reg;
    logic               hold_scheme_reg;
    logic               hold_tail_reg;
    uspq_pkg::out_t     out_reg, out_next;

    logic [7:0]         b;
    logic               last;
    logic               is_ctrl, is_colon, is_qmark, is_letter, is_later, cand;
    logic               buf_empty, buf_full, flush_last, out_free;

    // decisions for an accepted byte
    logic               need_flush, store, clr_cnt, fl_scheme, fl_tail;
    logic               emit_byte, emit_marker;
    logic [1:0]         emit_part, emit_err;
    uspq_pkg::phase_t   acc_phase;
    logic               acc_discard;
    uspq_pkg::out_t     dir_out, flush_out, tail_out;
    logic [7:0]         fl_value;
    logic               load;

    assign b    = in_data.byte_in;
    assign last = in_data.url_last;

    assign is_ctrl   = (b < uspq_pkg::CH_SPACE) || (b == uspq_pkg::CH_DEL);
    assign is_colon  = (b == uspq_pkg::CH_COLON);
    assign is_qmark  = (b == uspq_pkg::CH_QMARK);
    assign is_letter = ((b >= uspq_pkg::CH_LO_A) && (b <= uspq_pkg::CH_LO_Z))
                    || ((b >= uspq_pkg::CH_UP_A) && (b <= uspq_pkg::CH_UP_Z));
    assign is_later  = ((b >= uspq_pkg::CH_DIG_0) && (b <= uspq_pkg::CH_DIG_9))
                    || (b == uspq_pkg::CH_PLUS) || (b == uspq_pkg::CH_MINUS)
                    || (b == uspq_pkg::CH_DOT);
    assign buf_empty = (count_reg == '0);
    assign buf_full  = (count_reg == CNT_W'(SCHEME_MAX));
    assign cand      = is_letter || (!buf_empty && is_later);

    assign flush_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        need_flush  = 1'b0;
        store       = 1'b0;
        clr_cnt     = 1'b0;
        fl_scheme   = 1'b0;
        fl_tail     = 1'b0;
        emit_byte   = 1'b0;
        emit_marker = 1'b0;
        emit_part   = uspq_pkg::PART_PATH;
        emit_err    = uspq_pkg::ERR_NONE;
        acc_phase   = phase_reg;
        acc_discard = discard_reg;
        priority if (discard_reg)
        begin
            if (last)
            begin
                acc_discard = 1'b0;
                acc_phase   = uspq_pkg::PH_SCHEME;
            end
        end
        else if (is_ctrl)
        begin
            emit_marker = 1'b1;
            emit_err    = uspq_pkg::ERR_CTRL_CHAR;
            clr_cnt     = 1'b1;
            acc_phase   = uspq_pkg::PH_SCHEME;
            acc_discard = !last;
        end
        else if ((phase_reg == uspq_pkg::PH_SCHEME) && is_colon && buf_empty)
        begin
            emit_marker = 1'b1;
            emit_err    = uspq_pkg::ERR_NO_SCHEME;
            acc_discard = !last;
        end
        else
        begin
            unique case (phase_reg)
                uspq_pkg::PH_SCHEME:
                begin
                    priority if (is_colon)
                    begin
                        need_flush = 1'b1;
                        fl_scheme  = 1'b1;
                        acc_phase  = uspq_pkg::PH_PATH;
                    end
                    else if (cand && !buf_full && !last)
                    begin
                        store = 1'b1;
                    end
                    else
                    begin
                        need_flush = !buf_empty;
                        fl_tail    = !is_qmark;
                        acc_phase  = is_qmark ? uspq_pkg::PH_QUERY : uspq_pkg::PH_PATH;
                        emit_byte  = buf_empty && !is_qmark;
                    end
                end
                uspq_pkg::PH_PATH:
                begin
                    acc_phase = is_qmark ? uspq_pkg::PH_QUERY : uspq_pkg::PH_PATH;
                    emit_byte = !is_qmark;
                end
                default:
                begin
                    emit_byte = 1'b1;
                    emit_part = uspq_pkg::PART_QUERY;
                end
            endcase
            if (last)
            begin
                acc_phase = uspq_pkg::PH_SCHEME;
                // end of URL with nothing to show for it
                if (!emit_byte && !need_flush)
                begin
                    emit_marker = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        dir_out.part       = emit_marker ? uspq_pkg::PART_NONE : emit_part;
        dir_out.value      = emit_marker ? 8'd0 : b;
        dir_out.error_code = emit_err;
        dir_out.url_end    = emit_marker || last;
        dir_out.run_end    = 1'b1;
    end

    // lowercase on scheme release
    always_comb
    begin
        fl_value = rd_reg;
        if (hold_scheme_reg && (rd_reg >= uspq_pkg::CH_UP_A) && (rd_reg <= uspq_pkg::CH_UP_Z))
        begin
            fl_value = rd_reg | uspq_pkg::CASE_BIT;
        end
        flush_out.part       = hold_scheme_reg ? uspq_pkg::PART_SCHEME : uspq_pkg::PART_PATH;
        flush_out.value      = fl_value;
        flush_out.error_code = uspq_pkg::ERR_NONE;
        flush_out.url_end    = flush_last && !hold_tail_reg && hold_last_reg;
        flush_out.run_end    = flush_last && !hold_tail_reg;

        tail_out.part       = uspq_pkg::PART_PATH;
        tail_out.value      = hold_byte_reg;
        tail_out.error_code = uspq_pkg::ERR_NONE;
        tail_out.url_end    = hold_last_reg;
        tail_out.run_end    = 1'b1;
    end

    assign load = (cmd.take && (emit_byte || emit_marker)) || cmd.emit_flush || cmd.emit_tail;

    always_comb
    begin
        phase_next     = phase_reg;
        discard_next   = discard_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (cmd.take)
        begin
            phase_next   = acc_phase;
            discard_next = acc_discard;
            idx_next     = '0;
            if (store)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (clr_cnt)
            begin
                count_next = '0;
            end
        end
        if (cmd.emit_flush)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (flush_last)
            begin
                count_next = '0;
            end
        end
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        priority if (cmd.emit_flush)
        begin
            out_next = flush_out;
        end
        else if (cmd.emit_tail)
        begin
            out_next = tail_out;
        end
        else if (load)
        begin
            out_next = dir_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uspq_pkg::PH_SCHEME;
            discard_reg   <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            discard_reg   <= discard_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.take)
        begin
            hold_byte_reg   <= b;
            hold_last_reg   <= last;
            hold_scheme_reg <= fl_scheme;
            hold_tail_reg   <= fl_tail;
        end
    end

    // candidate buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.take && store)
        begin
            buf_mem[count_reg[IDX_W-1:0]] <= b;
        end
        if (cmd.rd)
        begin
            rd_reg <= buf_mem[idx_reg];
        end
    end

    assign sts.need_flush = need_flush;
    assign sts.flush_last = flush_last;
    assign sts.has_tail   = hold_tail_reg;
    assign sts.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hw/rtl/uspq_ctrl.sv */
// Controller: sequences byte acceptance and release of held scheme candidates.
`timescale 1ns / 1ps

module uspq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  uspq_pkg::sts_t sts,
    output uspq_pkg::cmd_t cmd
);

    uspq_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.take       = 1'b0;
        cmd.rd         = 1'b0;
        cmd.emit_flush = 1'b0;
        cmd.emit_tail  = 1'b0;
        in_stall       = 1'b1;
        unique case (state_reg)
            uspq_pkg::ST_IDLE:
            begin
                in_stall = !sts.out_free;
                cmd.take = in_valid && sts.out_free;
                if (cmd.take && sts.need_flush)
                begin
                    state_next = uspq_pkg::ST_READ;
                end
            end
            uspq_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = uspq_pkg::ST_EMIT;
            end
            uspq_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    priority if (!sts.flush_last)
                    begin
                        state_next = uspq_pkg::ST_READ;
                    end
                    else if (sts.has_tail)
                    begin
                        state_next = uspq_pkg::ST_TAIL;
                    end
                    else
                    begin
                        state_next = uspq_pkg::ST_IDLE;
                    end
                end
            end
            uspq_pkg::ST_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_tail = 1'b1;
                    state_next    = uspq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uspq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uspq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/url_scheme_path_query_splitter.sv */
// Top level of the URL scheme/path/query splitter.
//
//   channel   dir   handshake                 payload
//   byte_*    in    byte_valid / byte_stall   byte_data (uspq_pkg::in_t)
//   tag_*     out   tag_valid  / tag_stall    tag_data  (uspq_pkg::out_t)
//
// A byte that is stored, dropped, or tagged directly is handled as it is accepted.
// A byte that releases N held candidates starts a release: each candidate is
// read from the buffer, then loaded out; a trailing path byte is loaded out last.
// Reset clears control state at once; the buffer needs no clearing pass.
// tag_stall holds the output register; byte_stall is high during a release
// and whenever the output register cannot load.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module url_scheme_path_query_splitter #(
    parameter int SCHEME_MAX = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  uspq_pkg::in_t  byte_data,
    output logic           tag_valid,
    input  logic           tag_stall,
    output uspq_pkg::out_t tag_data
);

    uspq_pkg::cmd_t cmd;
    uspq_pkg::sts_t sts;

    logic byte_take, tag_held, tag_err, tag_closed;

    uspq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_valid),
        .in_stall (byte_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    uspq_dp #(
        .SCHEME_MAX (SCHEME_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (byte_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (tag_valid),
        .out_stall (tag_stall),
        .out_data  (tag_data)
    );

    assign byte_take  = byte_valid && !byte_stall;
    assign tag_held   = tag_valid && tag_stall;
    assign tag_err    = tag_valid && (tag_data.error_code != uspq_pkg::ERR_NONE);
    assign tag_closed = tag_data.url_end && tag_data.run_end
                     && (tag_data.part == uspq_pkg::PART_NONE);

    // no input transaction while a result is held back
    `ASSERT_SAME(a_no_take_when_full, clk, rst_n, byte_take, !tag_held)
    // error markers close the URL
    `ASSERT_SAME(a_err_closes, clk, rst_n, tag_err, tag_closed)
    // the last result of a URL is also the last of its byte
    `ASSERT_SAME(a_url_end_run_end, clk, rst_n, tag_valid && tag_data.url_end, tag_data.run_end)
    // a held-back result stays offered
    `ASSERT_NEXT(a_stall_holds_valid, clk, rst_n, tag_held, tag_valid)

endmodule
